>>> rtl/dpws_pkg.sv
// Package: shared types, constants and codes of the double pulse weld sequencer.
`timescale 1ns / 1ps
package dpws_pkg;

  // Register indexes on the configuration port
  localparam int unsigned CfgIdxW = 8;
  localparam logic [CfgIdxW-1:0] CFG_FIRST_PULSE  = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_SECOND_PULSE = 8'd1;
  localparam logic [CfgIdxW-1:0] CFG_AUTO_MODE    = 8'd2;
  localparam logic [CfgIdxW-1:0] CFG_AUTO_HOLD    = 8'd3;
  localparam int unsigned CfgDataW = 7;

  // Limits and phase lengths
  localparam logic [12:0] ARM_MV        = 13'd1000;
  localparam logic [6:0]  FIRST_MAX_MS  = 7'd30;
  localparam logic [6:0]  SECOND_MAX_MS = 7'd50;
  localparam logic [6:0]  GAP_MAX_MS    = 7'd10;
  localparam logic [9:0]  TAIL_MS       = 10'd10;
  localparam logic [9:0]  HOLDOFF_MS    = 10'd500;
  localparam logic [11:0] HOLD_MIN_MS   = 12'd100;
  localparam int unsigned HOLD_STEP_MS  = 500;
  localparam logic [11:0] HOLD_SAT      = 12'd4095;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_FIRST   = 3'd1,
    PH_GAP     = 3'd2,
    PH_SECOND  = 3'd3,
    PH_TAIL    = 3'd4,
    PH_HOLDOFF = 3'd5
  } phase_e;

  typedef struct packed {
    logic [6:0] first_pulse_ms;
    logic [6:0] second_pulse_ms;
    logic       auto_mode;
    logic [2:0] auto_hold_halfsec;
  } cfg_t;

  typedef struct packed {
    logic [12:0] cell_low_mv;
    logic [12:0] cell_high_mv;
    logic        manual_trigger;
    logic        contact_sense;
  } in_item_t;

  typedef struct packed {
    logic pulse_drive;
    logic buzzer_on;
    logic sequence_busy;
    logic weld_armed;
  } res_t;

endpackage

>>> rtl/dpws_in_if.sv
// Input channel: one millisecond tick sample per transaction.
`timescale 1ns / 1ps
interface dpws_in_if;
  logic        valid;
  logic        ready;
  logic [12:0] cell_low_mv;
  logic [12:0] cell_high_mv;
  logic        manual_trigger;
  logic        contact_sense;

  modport source (output valid, output cell_low_mv, output cell_high_mv,
                  output manual_trigger, output contact_sense, input ready);
  modport sink   (input valid, input cell_low_mv, input cell_high_mv,
                  input manual_trigger, input contact_sense, output ready);
endinterface

>>> rtl/dpws_out_if.sv
// Output channel: drive and status flags, one transaction per input tick.
`timescale 1ns / 1ps
interface dpws_out_if;
  logic valid;
  logic ready;
  logic pulse_drive;
  logic buzzer_on;
  logic sequence_busy;
  logic weld_armed;

  modport source (output valid, output pulse_drive, output buzzer_on,
                  output sequence_busy, output weld_armed, input ready);
  modport sink   (input valid, input pulse_drive, input buzzer_on,
                  input sequence_busy, input weld_armed, output ready);
endinterface

>>> rtl/dpws_cfg_regs.sv
// Configuration register file of the weld sequencer.
`timescale 1ns / 1ps
module dpws_cfg_regs
  import dpws_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FIRST_PULSE:  cfg_d.first_pulse_ms    = cfg_wdata_i;
        CFG_SECOND_PULSE: cfg_d.second_pulse_ms   = cfg_wdata_i;
        CFG_AUTO_MODE:    cfg_d.auto_mode         = cfg_wdata_i[0];
        CFG_AUTO_HOLD:    cfg_d.auto_hold_halfsec = cfg_wdata_i[2:0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_pulse_ms    <= 7'd3;
      cfg_q.second_pulse_ms   <= 7'd5;
      cfg_q.auto_mode         <= 1'b0;
      cfg_q.auto_hold_halfsec <= 3'd2;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/dpws_step.sv
// Sequencer state (phase, phase timer, hold count) and its per-tick update.
`timescale 1ns / 1ps
module dpws_step
  import dpws_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  cfg_t     cfg_i,
  input  in_item_t item_i,
  output res_t     res_o
);

  phase_e      phase_q, phase_d;
  logic [9:0]  timer_q, timer_d;
  logic [11:0] hold_q, hold_d;

  function automatic logic [9:0] phase_len(phase_e p, cfg_t c);
    logic [9:0] len;
    case (p)
      PH_FIRST:   len = {3'd0, c.first_pulse_ms};
      PH_GAP:     len = (c.first_pulse_ms > GAP_MAX_MS) ? {3'd0, GAP_MAX_MS}
                                                        : {3'd0, c.first_pulse_ms};
      PH_SECOND:  len = {3'd0, c.second_pulse_ms};
      PH_TAIL:    len = TAIL_MS;
      PH_HOLDOFF: len = HOLDOFF_MS;
      default:    len = 10'd0;
    endcase
    return len;
  endfunction

  function automatic phase_e next_phase(phase_e p, cfg_t c);
    phase_e n;
    case (p)
      PH_FIRST:  n = PH_GAP;
      PH_GAP:    n = PH_SECOND;
      PH_SECOND: n = PH_TAIL;
      PH_TAIL:   n = c.auto_mode ? PH_IDLE : PH_HOLDOFF;
      default:   n = PH_IDLE;
    endcase
    return n;
  endfunction

  // Zero-length phases are skipped; the tail never has zero length, so
  // at most three skips are possible.
  function automatic phase_e enter_phase(phase_e p, cfg_t c);
    phase_e n;
    n = p;
    for (int i = 0; i < 3; i++) begin
      if (n != PH_IDLE && phase_len(n, c) == 10'd0) n = next_phase(n, c);
    end
    return n;
  endfunction

  function automatic logic [11:0] hold_need(logic [2:0] halfsec);
    logic [11:0] need;
    need = 12'(32'(halfsec) * HOLD_STEP_MS);
    if (need < HOLD_MIN_MS) need = HOLD_MIN_MS;
    return need;
  endfunction

  logic        armed;
  logic        fire;
  logic [11:0] hold_inc;
  logic [9:0]  timer_inc;

  assign armed = (item_i.cell_low_mv > ARM_MV) && (item_i.cell_high_mv > ARM_MV) &&
                 (cfg_i.first_pulse_ms <= FIRST_MAX_MS) &&
                 (cfg_i.second_pulse_ms <= SECOND_MAX_MS);

  assign hold_inc  = (hold_q == HOLD_SAT) ? hold_q : hold_q + 12'd1;
  assign timer_inc = timer_q + 10'd1;

  always_comb begin
    phase_d = phase_q;
    timer_d = timer_q;
    hold_d  = hold_q;
    fire    = 1'b0;
    if (phase_q == PH_IDLE) begin
      if (armed && !cfg_i.auto_mode) begin
        hold_d = 12'd0;
        fire   = item_i.manual_trigger;
      end else if (armed && item_i.contact_sense) begin
        hold_d = hold_inc;
        fire   = hold_inc >= hold_need(cfg_i.auto_hold_halfsec);
      end else begin
        hold_d = 12'd0;
      end
      if (fire) begin
        hold_d  = 12'd0;
        phase_d = enter_phase(PH_FIRST, cfg_i);
        timer_d = 10'd0;
      end
    end else begin
      timer_d = timer_inc;
      if (timer_inc >= phase_len(phase_q, cfg_i)) begin
        phase_d = enter_phase(next_phase(phase_q, cfg_i), cfg_i);
        timer_d = 10'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      timer_q <= 10'd0;
      hold_q  <= 12'd0;
    end else if (en_i) begin
      phase_q <= phase_d;
      timer_q <= timer_d;
      hold_q  <= hold_d;
    end
  end

  // Flags follow the phase after this tick's update
  assign res_o.pulse_drive   = (phase_d == PH_FIRST) || (phase_d == PH_SECOND);
  assign res_o.buzzer_on     = (phase_d == PH_FIRST) || (phase_d == PH_GAP) ||
                               (phase_d == PH_SECOND) || (phase_d == PH_TAIL);
  assign res_o.sequence_busy = phase_d != PH_IDLE;
  assign res_o.weld_armed    = armed;

endmodule

>>> rtl/double_pulse_weld_sequencer.sv
// Top level of the double pulse weld sequencer: channels, pipeline registers.
`timescale 1ns / 1ps
// One input transaction per millisecond tick carries both cell voltages, the
// weld trigger and the contact sense; each yields exactly one output
// transaction with the pulse drive, buzzer, busy and armed flags as they stand
// after that tick. A transaction is accepted every cycle while the output is
// not stalled. Each accepted transaction is held in the input register, then
// the state update (phase, phase timer, hold count) feeds the result register.
// Output stalls back up through the input register: while a result waits, the
// input side takes at most one more transaction and then holds ready low. A
// firing runs first pulse, a gap of min(first pulse, 10) ms, second pulse, a
// 10 ms tail, then a 500 ms holdoff in manual mode; zero-length phases are
// skipped. Arming needs both cells above 1000 mV, first pulse at most 30 ms and
// second at most 50 ms. Auto mode fires after contact has been held for
// max(hold*500, 100) ticks. Configuration is written by index 0..3 (first
// pulse, second pulse, auto mode, auto hold); the user must write it only while
// no transaction is in flight, as the block itself does not enforce this.
// Other indexes are ignored.
module double_pulse_weld_sequencer
  import dpws_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  dpws_in_if.sink             in_ch,
  dpws_out_if.source          out_ch
);

  cfg_t     cfg;
  res_t     res;

  logic     in_valid_q;
  in_item_t in_item_q;
  logic     out_valid_q;
  res_t     out_res_q;
  logic     advance;

  dpws_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Move the held sample into the result register when that slot is free or its result is taken
  assign advance     = in_valid_q && (!out_valid_q || out_ch.ready);
  assign in_ch.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.ready && in_ch.valid) begin
      in_item_q.cell_low_mv    <= in_ch.cell_low_mv;
      in_item_q.cell_high_mv   <= in_ch.cell_high_mv;
      in_item_q.manual_trigger <= in_ch.manual_trigger;
      in_item_q.contact_sense  <= in_ch.contact_sense;
    end
  end

  // State advances only on the tick that moves into the result register
  dpws_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .cfg_i  (cfg),
    .item_i (in_item_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= res;
    end
  end

  assign out_ch.valid         = out_valid_q;
  assign out_ch.pulse_drive   = out_res_q.pulse_drive;
  assign out_ch.buzzer_on     = out_res_q.buzzer_on;
  assign out_ch.sequence_busy = out_res_q.sequence_busy;
  assign out_ch.weld_armed    = out_res_q.weld_armed;

endmodule

>>> tb/tb_double_pulse_weld_sequencer.sv
// Testbench for the double pulse weld sequencer: self-predicting, handshake-driven checks.
`timescale 1ns / 1ps
// Each input transaction is one millisecond tick. The bench keeps its own copy of
// the sequencer state (phase, phase timer, contact hold count) and of the four
// registers. At every accepted input transaction it advances that copy and queues
// the four flags expected for the tick. A separate process pops the queue on every
// accepted output transaction and compares each flag.
//
// Both channel sides idle at random before each transaction, with runs of
// back-to-back traffic mixed in. Registers are only written with the pipeline
// empty, meaning every queued expectation has been seen. The sequencer phase itself
// may still be mid-weld at that point, which is how the mid-sequence
// reconfiguration cases are reached.
module tb_double_pulse_weld_sequencer;
  import dpws_pkg::*;

  // Bench copies of the timing limits
  localparam int unsigned ArmMv       = 1000;
  localparam int unsigned FirstMaxMs  = 30;
  localparam int unsigned SecondMaxMs = 50;
  localparam int unsigned GapCapMs    = 10;
  localparam int unsigned TailMs      = 10;
  localparam int unsigned HoldoffMs   = 500;
  localparam int unsigned HoldStepMs  = 500;
  localparam int unsigned HoldMinMs   = 100;
  localparam int unsigned HoldSat     = 4095;

  // Indexes outside the register map; writes there must be dropped
  localparam logic [CfgIdxW-1:0] CFG_UNUSED_LO = 8'd4;
  localparam logic [CfgIdxW-1:0] CFG_UNUSED_HI = 8'hFF;

  localparam int unsigned RandomTicks = 200;
  // Longest run is about 1.6k ticks; this watchdog limit in clock cycles is several times that run's length
  localparam int unsigned CycleLimit  = 250_000;

  localparam int SideIn  = 0;
  localparam int SideOut = 1;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  dpws_in_if  in_if ();
  dpws_out_if out_if ();

  double_pulse_weld_sequencer dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_ch      (in_if),
    .out_ch     (out_if)
  );

  // Predictor state
  cfg_t        cur_cfg;
  phase_e      seq_phase;
  logic [9:0]  seq_timer;
  logic [11:0] contact_ms;

  res_t        expected_flags [$];
  int unsigned flag_errors;
  int unsigned cycle_cnt;
  int          quiet_left [2];
  logic        contact_run;   // held contact level for the random traffic
  res_t        want_flags;
  res_t        got_flags;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic int unsigned phase_len(phase_e p);
    case (p)
      PH_FIRST:   return int'(cur_cfg.first_pulse_ms);
      PH_GAP: begin
        if (cur_cfg.first_pulse_ms > GapCapMs) return GapCapMs;
        return int'(cur_cfg.first_pulse_ms);
      end
      PH_SECOND:  return int'(cur_cfg.second_pulse_ms);
      PH_TAIL:    return TailMs;
      PH_HOLDOFF: return HoldoffMs;
      default:    return 0;
    endcase
  endfunction

  function automatic phase_e phase_after(phase_e p);
    case (p)
      PH_FIRST:  return PH_GAP;
      PH_GAP:    return PH_SECOND;
      PH_SECOND: return PH_TAIL;
      PH_TAIL: begin
        // holdoff only follows in manual mode, decided when the tail ends
        if (cur_cfg.auto_mode) return PH_IDLE;
        return PH_HOLDOFF;
      end
      default:   return PH_IDLE;
    endcase
  endfunction

  // Zero-length phases fall straight through to the next one
  function automatic void enter_phase(phase_e p);
    phase_e q;
    q = p;
    while (q != PH_IDLE && phase_len(q) == 0) q = phase_after(q);
    seq_phase = q;
    seq_timer = '0;
  endfunction

  // One millisecond tick of the sequencer; returns the flags after the update
  function automatic res_t advance_weld_seq(in_item_t t);
    logic        armed;
    logic        fire;
    int unsigned need;
    res_t        r;
    armed = (t.cell_low_mv > ArmMv) && (t.cell_high_mv > ArmMv) &&
            (cur_cfg.first_pulse_ms <= FirstMaxMs) &&
            (cur_cfg.second_pulse_ms <= SecondMaxMs);
    if (seq_phase == PH_IDLE) begin
      fire = 1'b0;
      if (armed && !cur_cfg.auto_mode) begin
        contact_ms = '0;
        fire = t.manual_trigger;
      end else if (armed && t.contact_sense) begin
        need = int'(cur_cfg.auto_hold_halfsec) * HoldStepMs;
        if (need < HoldMinMs) need = HoldMinMs;
        if (contact_ms < HoldSat) contact_ms = contact_ms + 12'd1;
        fire = (contact_ms >= need);
      end else begin
        contact_ms = '0;
      end
      if (fire) begin
        contact_ms = '0;
        enter_phase(PH_FIRST);
      end
    end else begin
      seq_timer = seq_timer + 10'd1;
      // a length cut below the elapsed time ends the phase right here
      if (seq_timer >= phase_len(seq_phase)) enter_phase(phase_after(seq_phase));
    end
    r.pulse_drive   = (seq_phase == PH_FIRST) || (seq_phase == PH_SECOND);
    r.buzzer_on     = (seq_phase >= PH_FIRST) && (seq_phase <= PH_TAIL);
    r.sequence_busy = (seq_phase != PH_IDLE);
    r.weld_armed    = armed;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Per-transaction wait drawn at random, with occasional runs of zero waits
  function automatic int draw_wait(int side);
    if (quiet_left[side] > 0) begin
      quiet_left[side] = quiet_left[side] - 1;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      quiet_left[side] = $urandom_range(10, 60);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  function automatic in_item_t make_tick(logic [12:0] lo, logic [12:0] hi,
                                         logic trig, logic con);
    in_item_t t;
    t.cell_low_mv    = lo;
    t.cell_high_mv   = hi;
    t.manual_trigger = trig;
    t.contact_sense  = con;
    return t;
  endfunction

  // Anything at all in every field
  function automatic in_item_t noise_tick();
    return make_tick(13'($urandom_range(0, 8191)), 13'($urandom_range(0, 8191)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endfunction

  // Starts at a falling edge, ends at the rising edge that accepts the tick; valid stays up if the next tick follows
  task automatic send_tick(in_item_t t);
    int gap;
    gap = draw_wait(SideIn);
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.cell_low_mv    = t.cell_low_mv;
    in_if.cell_high_mv   = t.cell_high_mv;
    in_if.manual_trigger = t.manual_trigger;
    in_if.contact_sense  = t.contact_sense;
    in_if.valid          = 1'b1;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    expected_flags.push_back(advance_weld_seq(t));
  endtask

  // Leaves the bench at a falling edge with nothing in flight
  task automatic wait_drained();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (expected_flags.size() != 0) @(negedge clk);
  endtask

  // Only called with the pipeline drained
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = data;
    case (idx)
      CFG_FIRST_PULSE:  cur_cfg.first_pulse_ms    = data;
      CFG_SECOND_PULSE: cur_cfg.second_pulse_ms   = data;
      CFG_AUTO_MODE:    cur_cfg.auto_mode         = data[0];
      CFG_AUTO_HOLD:    cur_cfg.auto_hold_halfsec = data[2:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Inputs hardly matter mid-weld; fill with noise until the phase is idle
  task automatic run_until_idle();
    while (seq_phase != PH_IDLE) send_tick(noise_tick());
  endtask

  // Armed contact held until the auto fire happens (trigger is don't-care)
  task automatic hold_contact_until_fire();
    while (seq_phase == PH_IDLE)
      send_tick(make_tick(13'($urandom_range(1001, 8191)),
                          13'($urandom_range(1001, 8191)),
                          1'($urandom_range(0, 1)), 1'b1));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset register values: arming edges on both cells; the one trigger comes on a disarmed tick
  task automatic test_arm_thresholds();
    send_tick(make_tick(13'd0,    13'd0,    1'b0, 1'b0));
    send_tick(make_tick(13'd1000, 13'd1000, 1'b0, 1'b1));
    send_tick(make_tick(13'd1001, 13'd1000, 1'b0, 1'b0));
    send_tick(make_tick(13'd1000, 13'd1001, 1'b0, 1'b1));
    send_tick(make_tick(13'd1001, 13'd1001, 1'b0, 1'b1));
    send_tick(make_tick(13'd5000, 13'd5000, 1'b0, 1'b0));
    send_tick(make_tick(13'h1FFF, 13'h1FFF, 1'b0, 1'b1));
    send_tick(make_tick(13'h1FFF, 13'd0,    1'b1, 1'b0));
  endtask

  // Pulse length limits gate arming; a good setting at the limits fires
  task automatic test_pulse_limits();
    wait_drained();
    write_reg(CFG_FIRST_PULSE, 7'd31);
    send_tick(make_tick(13'd2000, 13'd2000, 1'b1, 1'b0));
    wait_drained();
    write_reg(CFG_FIRST_PULSE, 7'd30);
    write_reg(CFG_SECOND_PULSE, 7'd51);
    send_tick(make_tick(13'd2000, 13'd2000, 1'b1, 1'b0));
    wait_drained();
    write_reg(CFG_FIRST_PULSE, 7'h7F);
    write_reg(CFG_SECOND_PULSE, 7'h7F);
    send_tick(make_tick(13'd4000, 13'd4000, 1'b1, 1'b1));
    wait_drained();
    write_reg(CFG_FIRST_PULSE, 7'd30);
    write_reg(CFG_SECOND_PULSE, 7'd50);
    send_tick(make_tick(13'd3000, 13'd3000, 1'b1, 1'b0));
    run_until_idle();
  endtask

  // Zero pulse lengths skip phases; gap is capped at 10 ms
  task automatic test_zero_length_phases();
    wait_drained();
    write_reg(CFG_FIRST_PULSE, 7'd0);
    write_reg(CFG_SECOND_PULSE, 7'd0);
    // fire lands directly in the tail
    send_tick(make_tick(13'd1500, 13'd1500, 1'b1, 1'b0));
    wait_drained();
    write_reg(CFG_AUTO_MODE, 7'd1);       // tail ends straight to idle
    run_until_idle();
    wait_drained();
    write_reg(CFG_FIRST_PULSE, 7'd12);
    write_reg(CFG_AUTO_HOLD, 7'd0);
    hold_contact_until_fire();
    run_until_idle();
  endtask

  // Register writes while the weld runs: shortened, zeroed and lengthened
  // phases, and auto mode switched on before the tail ends
  task automatic test_mid_sequence_config();
    wait_drained();
    write_reg(CFG_AUTO_MODE, 7'd0);
    write_reg(CFG_FIRST_PULSE, 7'd30);
    write_reg(CFG_SECOND_PULSE, 7'd50);
    send_tick(make_tick(13'd2500, 13'd2500, 1'b1, 1'b0));
    repeat (20) send_tick(noise_tick());
    wait_drained();
    write_reg(CFG_FIRST_PULSE, 7'd15);    // below elapsed time
    repeat (12) send_tick(noise_tick());
    wait_drained();
    write_reg(CFG_SECOND_PULSE, 7'd0);
    repeat (3) send_tick(noise_tick());
    wait_drained();
    write_reg(CFG_AUTO_MODE, 7'd1);       // tail ends without holdoff
    run_until_idle();
    wait_drained();
    write_reg(CFG_AUTO_MODE, 7'd0);
    write_reg(CFG_FIRST_PULSE, 7'd5);
    write_reg(CFG_SECOND_PULSE, 7'd5);
    send_tick(make_tick(13'd1200, 13'd1200, 1'b1, 1'b1));
    repeat (2) send_tick(noise_tick());
    wait_drained();
    write_reg(CFG_FIRST_PULSE, 7'd40);    // longer pulse, disarms meanwhile
    repeat (50) send_tick(noise_tick());
    wait_drained();
    write_reg(CFG_AUTO_MODE, 7'd1);       // second pulse running: no holdoff
    run_until_idle();
  endtask

  // Auto fire: contact loss and disarm restart the count; register decode
  task automatic test_auto_hold();
    wait_drained();
    write_reg(CFG_FIRST_PULSE, 7'd4);
    write_reg(CFG_SECOND_PULSE, 7'd6);
    write_reg(CFG_AUTO_MODE, 7'd1);
    write_reg(CFG_AUTO_HOLD, 7'h78);      // upper data bits ignored, hold 0
    // must be dropped; a decoder on low bits only would hit a real register
    write_reg(CFG_UNUSED_HI, 7'd7);
    write_reg(CFG_UNUSED_LO, 7'h7F);
    repeat (60) send_tick(make_tick(13'd3000, 13'd3000, 1'b1, 1'b1));
    send_tick(make_tick(13'd3000, 13'd3000, 1'b0, 1'b0));
    repeat (90) send_tick(make_tick(13'd3000, 13'd3000, 1'b0, 1'b1));
    send_tick(make_tick(13'd900, 13'd3000, 1'b0, 1'b1));
    hold_contact_until_fire();
    run_until_idle();
  endtask

  // Mostly armed, well-formed ticks in episodes of random register settings;
  // episodes end wherever the weld happens to be
  task automatic test_random_traffic();
    int          sent;
    int          len;
    int          r;
    logic [12:0] lo;
    logic [12:0] hi;
    logic        trig;
    sent = 0;
    while (sent < RandomTicks) begin
      wait_drained();
      r = $urandom_range(0, 9);
      if (r < 7)       write_reg(CFG_FIRST_PULSE, 7'($urandom_range(0, 30)));
      else if (r == 7) write_reg(CFG_FIRST_PULSE, ($urandom_range(0, 1) != 0) ? 7'd30 : 7'd0);
      else             write_reg(CFG_FIRST_PULSE, 7'($urandom_range(31, 127)));
      r = $urandom_range(0, 9);
      if (r < 7)       write_reg(CFG_SECOND_PULSE, 7'($urandom_range(0, 50)));
      else if (r == 7) write_reg(CFG_SECOND_PULSE, ($urandom_range(0, 1) != 0) ? 7'd50 : 7'd0);
      else             write_reg(CFG_SECOND_PULSE, 7'($urandom_range(51, 127)));
      // bit 0 picks the mode; the other data bits are random junk
      write_reg(CFG_AUTO_MODE, {6'($urandom_range(0, 63)), 1'($urandom_range(0, 3) != 0)});
      r = $urandom_range(0, 9);
      if (r < 7)      write_reg(CFG_AUTO_HOLD, {4'($urandom_range(0, 15)), 3'd0});
      else if (r < 9) write_reg(CFG_AUTO_HOLD, {4'($urandom_range(0, 15)), 3'd1});
      else            write_reg(CFG_AUTO_HOLD, 7'($urandom_range(2, 7)));
      len = $urandom_range(40, 250);
      repeat (len) begin
        if ($urandom_range(0, 99) < 85) begin
          // held contact with rare drops, now and then a trigger press
          if (contact_run) contact_run = ($urandom_range(0, 149) != 0);
          else             contact_run = ($urandom_range(0, 9) == 0);
          lo   = 13'($urandom_range(1001, 5000));
          hi   = 13'($urandom_range(1001, 5000));
          trig = ($urandom_range(0, 7) == 0);
          send_tick(make_tick(lo, hi, trig, contact_run));
        end else begin
          send_tick(noise_tick());
        end
      end
      sent = sent + len;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random ready stalls, and the flag checker
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    out_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = draw_wait(SideOut);
      @(negedge clk);
      if (stall > 0) begin
        out_if.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_if.ready = 1'b1;
      @(posedge clk);
      while (!out_if.valid) @(posedge clk);
    end
  end

  task automatic log_flag_error(string what);
    flag_errors = flag_errors + 1;
    if (flag_errors <= 10) $display("[%0t] %s", $realtime, what);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      got_flags.pulse_drive   = out_if.pulse_drive;
      got_flags.buzzer_on     = out_if.buzzer_on;
      got_flags.sequence_busy = out_if.sequence_busy;
      got_flags.weld_armed    = out_if.weld_armed;
      if (expected_flags.size() == 0) begin
        log_flag_error($sformatf("unexpected result: drive=%b buzz=%b busy=%b arm=%b",
                                 got_flags.pulse_drive, got_flags.buzzer_on,
                                 got_flags.sequence_busy, got_flags.weld_armed));
      end else begin
        want_flags = expected_flags.pop_front();
        if (got_flags.pulse_drive   !== want_flags.pulse_drive ||
            got_flags.buzzer_on     !== want_flags.buzzer_on ||
            got_flags.sequence_busy !== want_flags.sequence_busy ||
            got_flags.weld_armed    !== want_flags.weld_armed)
          log_flag_error($sformatf(
            "flag mismatch drive/buzz/busy/arm: exp %b%b%b%b got %b%b%b%b",
            want_flags.pulse_drive, want_flags.buzzer_on,
            want_flags.sequence_busy, want_flags.weld_armed,
            got_flags.pulse_drive, got_flags.buzzer_on,
            got_flags.sequence_busy, got_flags.weld_armed));
      end
    end
  end

  // Watchdog
  initial begin
    wait (cycle_cnt >= CycleLimit);
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    cycle_cnt             = 0;
    flag_errors           = 0;
    quiet_left[SideIn]    = 0;
    quiet_left[SideOut]   = 0;
    contact_run           = 1'b1;
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_idx               = '0;
    cfg_wdata             = '0;
    in_if.valid           = 1'b0;
    in_if.cell_low_mv     = '0;
    in_if.cell_high_mv    = '0;
    in_if.manual_trigger  = 1'b0;
    in_if.contact_sense   = 1'b0;
    // register values and state after reset
    cur_cfg.first_pulse_ms    = 7'd3;
    cur_cfg.second_pulse_ms   = 7'd5;
    cur_cfg.auto_mode         = 1'b0;
    cur_cfg.auto_hold_halfsec = 3'd2;
    seq_phase                 = PH_IDLE;
    seq_timer                 = '0;
    contact_ms                = '0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_arm_thresholds();
    test_pulse_limits();
    test_zero_length_phases();
    test_mid_sequence_config();
    test_auto_hold();
    test_random_traffic();

    wait_drained();
    // two-stage pipeline; the extra wait catches any stray result
    repeat (6) @(posedge clk);
    if (flag_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
